@@ design/rgb_led_strip_frame_streamer_assert.svh @@
// assertion macros for the rgb led strip frame streamer
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef RGB_LED_STRIP_FRAME_STREAMER_ASSERT_SVH
`define RGB_LED_STRIP_FRAME_STREAMER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RLSFS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define RLSFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rlsfs_pkg.sv @@
// shared types, constants and command structs of the led strip frame streamer
// no dependencies
`default_nettype none

package rlsfs_pkg;

  // strip geometry
  localparam int LED_COUNT   = 256;
  localparam int START_BYTES = 4;
  localparam int END_BYTES   = 5;

  localparam int ADDR_W      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int FRAME_TOTAL = START_BYTES + 4 * LED_COUNT + END_BYTES;
  localparam int POS_W       = $clog2(FRAME_TOTAL);
  // wide enough for any led_index and for LED_COUNT itself
  localparam int IDX_EXT_W   = 13;

  localparam int BRIGHT_W = 5;
  localparam int COLOR_W  = 8;
  localparam int PIXEL_W  = 3 * COLOR_W;
  localparam int CFG_W    = BRIGHT_W;

  localparam logic [7:0]          HEADER_MARK = 8'hE0;
  localparam logic [7:0]          END_FILL    = 8'hFF;
  localparam logic [7:0]          ZERO_BYTE   = 8'h00;
  localparam logic [BRIGHT_W-1:0] MAX_BRIGHT  = 5'd31;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef enum logic [1:0] {
    ACT_SET_ONE   = 2'd0,
    ACT_SET_ALL   = 2'd1,
    ACT_CLEAR_ALL = 2'd2,
    ACT_EMIT      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_BRIGHTNESS  = 2'd0,
    CFG_COLOR_ORDER = 2'd1,
    CFG_UPDATE_EN   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE_ONE,
    ST_SWEEP,
    ST_CLEAR,
    ST_READ,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic write_one;
    logic sweep_write;
    logic clear_all;
    logic read_pix;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic update_enabled;
    logic sweep_last;
  } sts_t;

endpackage

`default_nettype wire

@@ design/rlsfs_ctrl.sv @@
// controller state machine of the led strip frame streamer
// depends on rlsfs_pkg
`default_nettype none

module rlsfs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [1:0]        action_i,
  input  wire rlsfs_pkg::sts_t   sts_i,
  output rlsfs_pkg::cmd_t        cmd_o,
  output logic                   busy
);

  rlsfs_pkg::state_e  state_q, state_d;
  rlsfs_pkg::action_e action;

  assign action = rlsfs_pkg::action_e'(action_i);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlsfs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rlsfs_pkg::ST_IDLE: begin
        if (start && sts_i.update_enabled) begin
          case (action)
            rlsfs_pkg::ACT_SET_ONE:   state_d = rlsfs_pkg::ST_WRITE_ONE;
            rlsfs_pkg::ACT_SET_ALL:   state_d = rlsfs_pkg::ST_SWEEP;
            rlsfs_pkg::ACT_CLEAR_ALL: state_d = rlsfs_pkg::ST_CLEAR;
            rlsfs_pkg::ACT_EMIT:      state_d = rlsfs_pkg::ST_READ;
            default:                  state_d = rlsfs_pkg::ST_IDLE;
          endcase
        end
      end
      rlsfs_pkg::ST_SWEEP: begin
        if (sts_i.sweep_last) begin
          state_d = rlsfs_pkg::ST_IDLE;
        end
      end
      rlsfs_pkg::ST_READ:      state_d = rlsfs_pkg::ST_EMIT;
      rlsfs_pkg::ST_WRITE_ONE: state_d = rlsfs_pkg::ST_IDLE;
      rlsfs_pkg::ST_CLEAR:     state_d = rlsfs_pkg::ST_IDLE;
      rlsfs_pkg::ST_EMIT:      state_d = rlsfs_pkg::ST_IDLE;
      default:                 state_d = rlsfs_pkg::ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o = '0;
    case (state_q)
      rlsfs_pkg::ST_IDLE:      cmd_o.load_item   = start;
      rlsfs_pkg::ST_WRITE_ONE: cmd_o.write_one   = 1'b1;
      rlsfs_pkg::ST_SWEEP:     cmd_o.sweep_write = 1'b1;
      rlsfs_pkg::ST_CLEAR:     cmd_o.clear_all   = 1'b1;
      rlsfs_pkg::ST_READ:      cmd_o.read_pix    = 1'b1;
      rlsfs_pkg::ST_EMIT:      cmd_o.load_out    = 1'b1;
      default:                 cmd_o = '0;
    endcase
  end

  assign busy = (state_q != rlsfs_pkg::ST_IDLE);

endmodule

`default_nettype wire

@@ design/rlsfs_datapath.sv @@
// datapath: config registers, pixel store, frame position and output word
// depends on rlsfs_pkg
`default_nettype none

module rlsfs_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rlsfs_pkg::cmd_t               cmd_i,
  output rlsfs_pkg::sts_t                    sts_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [rlsfs_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic [7:0]                    led_index_i,
  input  wire logic [7:0]                    red_i,
  input  wire logic [7:0]                    green_i,
  input  wire logic [7:0]                    blue_i,
  output logic                               result_valid_o,
  output logic [7:0]                         spi_byte_o,
  output logic                               frame_last_o
);

  // configuration registers
  logic [rlsfs_pkg::BRIGHT_W-1:0] bright_q;
  logic                           order_q;
  logic                           upd_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= rlsfs_pkg::MAX_BRIGHT;
      order_q  <= 1'b0;
      upd_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (rlsfs_pkg::cfg_idx_e'(cfg_idx_i))
        // a 5-bit write can never exceed the maximum brightness
        rlsfs_pkg::CFG_BRIGHTNESS:  bright_q <= cfg_wdata_i;
        rlsfs_pkg::CFG_COLOR_ORDER: order_q  <= cfg_wdata_i[0];
        rlsfs_pkg::CFG_UPDATE_EN:   upd_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [7:0]        led_index_q;
  rlsfs_pkg::pixel_t colour_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      led_index_q <= led_index_i;
      colour_q    <= {red_i, green_i, blue_i};
    end
  end

  // fill counter for set all
  rlsfs_pkg::addr_t sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.load_item) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_write) begin
      sweep_q <= sweep_q + rlsfs_pkg::addr_t'(1);
    end
  end

  assign sts_o.update_enabled = upd_en_q;
  assign sts_o.sweep_last     = (sweep_q == rlsfs_pkg::addr_t'(rlsfs_pkg::LED_COUNT - 1));

  // single write port
  logic [rlsfs_pkg::IDX_EXT_W-1:0] idx_ext;
  logic                            idx_in_range;
  logic                            wr_en;
  rlsfs_pkg::addr_t                wr_addr;

  assign idx_ext      = rlsfs_pkg::IDX_EXT_W'(led_index_q);
  assign idx_in_range = (idx_ext < rlsfs_pkg::IDX_EXT_W'(rlsfs_pkg::LED_COUNT));
  assign wr_en        = (cmd_i.write_one && idx_in_range) || cmd_i.sweep_write;
  assign wr_addr      = cmd_i.sweep_write ? sweep_q : idx_ext[rlsfs_pkg::ADDR_W-1:0];

  // pixel store
  rlsfs_pkg::pixel_t mem [rlsfs_pkg::LED_COUNT];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= colour_q;
    end
  end

  // per-entry valid bits, an entry not written since reset or clear reads as zero
  logic [rlsfs_pkg::LED_COUNT-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear_all) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // frame position and store read address
  rlsfs_pkg::pos_t  pos_q, pos_d;
  rlsfs_pkg::pos_t  rel;
  rlsfs_pkg::addr_t rd_addr;
  logic             pos_last;

  assign rel      = pos_q - rlsfs_pkg::pos_t'(rlsfs_pkg::START_BYTES);
  assign rd_addr  = rel[rlsfs_pkg::ADDR_W+1:2];
  assign pos_last = (pos_q == rlsfs_pkg::pos_t'(rlsfs_pkg::FRAME_TOTAL - 1));
  assign pos_d    = pos_last ? '0 : pos_q + rlsfs_pkg::pos_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.load_out) begin
      pos_q <= pos_d;
    end
  end

  // registered store read
  rlsfs_pkg::pixel_t rdata_q;
  logic              rvalid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_pix) begin
      rdata_q  <= mem[rd_addr];
      rvalid_q <= valid_q[rd_addr];
    end
  end

  // frame byte selection
  rlsfs_pkg::pixel_t pix;
  logic [7:0]        byte_d;

  assign pix = rvalid_q ? rdata_q : '0;

  always_comb begin
    if (pos_q < rlsfs_pkg::pos_t'(rlsfs_pkg::START_BYTES)) begin
      byte_d = rlsfs_pkg::ZERO_BYTE;
    end else if (rel >= rlsfs_pkg::pos_t'(4 * rlsfs_pkg::LED_COUNT)) begin
      byte_d = rlsfs_pkg::END_FILL;
    end else begin
      case (rel[1:0])
        2'd0:    byte_d = rlsfs_pkg::HEADER_MARK | {3'b000, bright_q};
        2'd2:    byte_d = pix[15:8];
        2'd1:    byte_d = order_q ? pix[7:0] : pix[23:16];
        default: byte_d = order_q ? pix[23:16] : pix[7:0];
      endcase
    end
  end

  // output word register, shown for one cycle
  logic       res_valid_q;
  logic [7:0] spi_byte_q;
  logic       frame_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.load_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      spi_byte_q   <= byte_d;
      frame_last_q <= pos_last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign spi_byte_o     = spi_byte_q;
  assign frame_last_o   = frame_last_q;

endmodule

`default_nettype wire

@@ design/rgb_led_strip_frame_streamer.sv @@
// top level of the rgb led strip frame streamer
// depends on rlsfs_pkg, rlsfs_ctrl, rlsfs_datapath and the assertion macro header
`default_nettype none

// Takes one action word when start is high and busy is low. An emit action
// gives one frame byte on spi_byte_o/frame_last_o, marked by result_valid_o
// for exactly one cycle, after a store read and then the output register;
// the receiver cannot stall, so it must take the word in that cycle. Busy
// covers an emit's read and output load, set one pixel's write, clear all's
// clear and set all's sweep (one store write per cycle through the single
// write port). With updates disabled an action is taken and dropped without
// raising busy. The store is cleared by per-entry valid bits, so no clearing
// pass is needed after reset. Configuration writes take effect at once and
// are meant to happen while busy is low and no result is pending.
module rgb_led_strip_frame_streamer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    action_i,
  input  wire logic [7:0]                    led_index_i,
  input  wire logic [7:0]                    red_i,
  input  wire logic [7:0]                    green_i,
  input  wire logic [7:0]                    blue_i,
  output logic                               result_valid_o,
  output logic [7:0]                         spi_byte_o,
  output logic                               frame_last_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [rlsfs_pkg::CFG_W-1:0]   cfg_wdata_i
);

  `include "rgb_led_strip_frame_streamer_assert.svh"

  rlsfs_pkg::cmd_t cmd;
  rlsfs_pkg::sts_t sts;

  // controller
  rlsfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // datapath
  rlsfs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .led_index_i    (led_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .result_valid_o (result_valid_o),
    .spi_byte_o     (spi_byte_o),
    .frame_last_o   (frame_last_o)
  );

  // an accepted emit with updates enabled gives its word after the store read and the output register
  `RLSFS_ASSERT_IMPL(a_emit_latency, start && !busy && sts.update_enabled && (action_i == rlsfs_pkg::ACT_EMIT), ##3 result_valid_o, "emit did not give a word three cycles after acceptance")
  // words never come back to back
  `RLSFS_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o, "result strobe held for two cycles")
  // the controller is idle again by the time a word is shown
  `RLSFS_ASSERT_IMPL(a_idle_on_result, result_valid_o, !busy, "busy while a result word is shown")
  // the fill sweep ends after its last store write
  `RLSFS_ASSERT_NEXT(a_sweep_end, cmd.sweep_write && sts.sweep_last, !busy, "fill sweep did not end after the last entry")

endmodule

`default_nettype wire
